// ===== hw/rtl/sae_pkg.sv =====
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types for the suffix automaton extend block: datapath operations
// and the status bundle that goes back to the controller.
// ----------------------------------------------------------------------------
package sae_pkg;

  // symbol field width on the ports
  localparam int SYM_W = 5;

  // one operation per cycle, issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_START,
    OP_REJECT,
    OP_ALLOC_NP,
    OP_SET_LEN_NP,
    OP_WALK_RD,
    OP_WALK1_SET,
    OP_LINK_NP_ROOT,
    OP_TAKE_Q,
    OP_READ_LQ,
    OP_LINK_NP_Q,
    OP_ALLOC_NQ,
    OP_LINK_NQ,
    OP_LINK_Q,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_WALK2_SET,
    OP_LINK_NP_NQ,
    OP_RESULT
  } sae_op_t;

  // datapath conditions seen by the controller
  typedef struct packed {
    logic full;
    logic bad;
    logic p_zero;
    logic guard_end;
    logic trans_zero;
    logic trans_is_q;
    logic lenq_match;
    logic copy_last;
    logic clear_last;
    logic out_free;
  } sae_status_t;

endpackage

// ===== hw/rtl/sae_ctrl.sv =====
// ----------------------------------------------------------------------------
// sae_ctrl
// Sequencer: clear sweep, checks, first link walk, clone, second walk, result.
// ----------------------------------------------------------------------------
module sae_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sae_pkg::sae_status_t st,
  output sae_pkg::sae_op_t    op
);

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_CHECK   = 15'b000000000000100,
    S_LEN     = 15'b000000000001000,
    S_W1_RD   = 15'b000000000010000,
    S_W1_EV   = 15'b000000000100000,
    S_W1_LP   = 15'b000000001000000,
    S_W1_LQ   = 15'b000000010000000,
    S_CL_LINK = 15'b000000100000000,
    S_CL_LQ   = 15'b000001000000000,
    S_CP_RD   = 15'b000010000000000,
    S_CP_WR   = 15'b000100000000000,
    S_W2_RD   = 15'b001000000000000,
    S_W2_EV   = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // decode next state and datapath operation
  always_comb begin
    state_next = state;
    op         = sae_pkg::OP_NONE;
    case (state)
      S_CLEAR: begin
        op = sae_pkg::OP_CLEAR;
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = sae_pkg::OP_START;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.full || st.bad) begin
          op         = sae_pkg::OP_REJECT;
          state_next = S_DONE;
        end else begin
          op         = sae_pkg::OP_ALLOC_NP;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        op         = sae_pkg::OP_SET_LEN_NP;
        state_next = S_W1_RD;
      end
      S_W1_RD: begin
        if (st.p_zero || st.guard_end) begin
          op         = sae_pkg::OP_LINK_NP_ROOT;
          state_next = S_DONE;
        end else begin
          op         = sae_pkg::OP_WALK_RD;
          state_next = S_W1_EV;
        end
      end
      S_W1_EV: begin
        if (st.trans_zero) begin
          op         = sae_pkg::OP_WALK1_SET;
          state_next = S_W1_RD;
        end else begin
          op         = sae_pkg::OP_TAKE_Q;
          state_next = S_W1_LP;
        end
      end
      S_W1_LP: begin
        op         = sae_pkg::OP_READ_LQ;
        state_next = S_W1_LQ;
      end
      S_W1_LQ: begin
        if (st.lenq_match) begin
          op         = sae_pkg::OP_LINK_NP_Q;
          state_next = S_DONE;
        end else begin
          op         = sae_pkg::OP_ALLOC_NQ;
          state_next = S_CL_LINK;
        end
      end
      S_CL_LINK: begin
        op         = sae_pkg::OP_LINK_NQ;
        state_next = S_CL_LQ;
      end
      S_CL_LQ: begin
        op         = sae_pkg::OP_LINK_Q;
        state_next = S_CP_RD;
      end
      S_CP_RD: begin
        op         = sae_pkg::OP_COPY_RD;
        state_next = S_CP_WR;
      end
      S_CP_WR: begin
        op         = sae_pkg::OP_COPY_WR;
        state_next = st.copy_last ? S_W2_RD : S_CP_RD;
      end
      S_W2_RD: begin
        if (st.p_zero || st.guard_end) begin
          op         = sae_pkg::OP_LINK_NP_NQ;
          state_next = S_DONE;
        end else begin
          op         = sae_pkg::OP_WALK_RD;
          state_next = S_W2_EV;
        end
      end
      S_W2_EV: begin
        if (st.trans_is_q) begin
          op         = sae_pkg::OP_WALK2_SET;
          state_next = S_W2_RD;
        end else begin
          op         = sae_pkg::OP_LINK_NP_NQ;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          op         = sae_pkg::OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // no item is taken during the clear sweep
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("item accepted during clear sweep");

  // a copy pass always ends in the second walk or continues the copy
  a_copy_flow: assert property (@(posedge clk) disable iff (rst)
    (state == S_CP_WR) |=> (state == S_CP_RD || state == S_W2_RD))
    else $error("copy pass left early");

  // a result is posted only from the done state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    (op == sae_pkg::OP_RESULT) |-> (state == S_DONE))
    else $error("result posted outside done state");

endmodule

// ===== hw/rtl/sae_dp.sv =====
// ----------------------------------------------------------------------------
// sae_dp
// Datapath: transition, link and length memories, walk registers, state
// counter and the result register.
// ----------------------------------------------------------------------------
module sae_dp #(
  parameter int MAX_STATES    = 4096,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sae_pkg::sae_op_t                  op,
  input  logic [sae_pkg::SYM_W-1:0]         symbol,
  input  logic [$clog2(MAX_STATES)-1:0]     last_state,
  input  logic                              out_stall,
  output sae_pkg::sae_status_t              st,
  output logic                              out_valid,
  output logic [$clog2(MAX_STATES)-1:0]     new_state,
  output logic                              table_full
);

  localparam int SW    = $clog2(MAX_STATES);
  localparam int TOTAL = MAX_STATES * ALPHABET_SIZE;
  localparam int AW    = $clog2(TOTAL);
  localparam int OW    = $clog2(ALPHABET_SIZE);

  // memories
  logic [SW-1:0] trans_mem [TOTAL];
  logic [SW-1:0] link_mem  [MAX_STATES];
  logic [SW-1:0] len_mem   [MAX_STATES];

  // working registers
  logic [sae_pkg::SYM_W-1:0] sym;
  logic [SW-1:0] p, np, q, nq, len_p, cnt;
  logic [SW:0]   guard;
  logic [OW-1:0] idx;
  logic [AW-1:0] clr, e_addr;
  logic [SW-1:0] rd_trans, rd_link, rd_len;
  logic          full_hit;

  // memory port controls
  logic          t_re, t_we, l_re, l_we, n_re, n_we;
  logic [AW-1:0] t_raddr, t_waddr;
  logic [SW-1:0] t_wdata, l_raddr, l_waddr, l_wdata, n_raddr, n_waddr, n_wdata;
  logic [AW-1:0] edge_addr, q_addr, nq_addr;

  assign edge_addr = AW'(p) * AW'(ALPHABET_SIZE) + AW'(sym);
  assign q_addr    = AW'(q) * AW'(ALPHABET_SIZE) + AW'(idx);
  assign nq_addr   = AW'(nq) * AW'(ALPHABET_SIZE) + AW'(idx);

  // status toward the controller
  always_comb begin
    st.full       = (cnt >= SW'(MAX_STATES - 2));
    st.bad        = (32'(sym) >= ALPHABET_SIZE) || (p == '0) || (p > cnt);
    st.p_zero     = (p == '0);
    st.guard_end  = (guard == (SW+1)'(MAX_STATES));
    st.trans_zero = (rd_trans == '0);
    st.trans_is_q = (rd_trans == q);
    st.lenq_match = (rd_len == len_p + SW'(1));
    st.copy_last  = (idx == OW'(ALPHABET_SIZE - 1));
    st.clear_last = (clr == AW'(TOTAL - 1));
    st.out_free   = !out_valid || !out_stall;
  end

  // steer memory ports by operation
  always_comb begin
    t_re = 1'b0; t_raddr = edge_addr;
    t_we = 1'b0; t_waddr = e_addr; t_wdata = np;
    l_re = 1'b0; l_raddr = p;
    l_we = 1'b0; l_waddr = np; l_wdata = SW'(1);
    n_re = 1'b0; n_raddr = p;
    n_we = 1'b0; n_waddr = np; n_wdata = rd_len + SW'(1);
    case (op)
      sae_pkg::OP_CLEAR: begin
        t_we = 1'b1; t_waddr = clr; t_wdata = '0;
        if (32'(clr) < MAX_STATES) begin
          l_we = 1'b1; l_waddr = clr[SW-1:0]; l_wdata = '0;
          n_we = 1'b1; n_waddr = clr[SW-1:0]; n_wdata = '0;
        end
      end
      sae_pkg::OP_ALLOC_NP:     n_re = 1'b1;
      sae_pkg::OP_SET_LEN_NP:   n_we = 1'b1;
      sae_pkg::OP_WALK_RD: begin
        t_re = 1'b1;
        l_re = 1'b1;
      end
      sae_pkg::OP_WALK1_SET:    t_we = 1'b1;
      sae_pkg::OP_LINK_NP_ROOT: l_we = 1'b1;
      sae_pkg::OP_TAKE_Q:       n_re = 1'b1;
      sae_pkg::OP_READ_LQ: begin
        n_re = 1'b1; n_raddr = q;
      end
      sae_pkg::OP_LINK_NP_Q: begin
        l_we = 1'b1; l_wdata = q;
      end
      sae_pkg::OP_ALLOC_NQ: begin
        n_we = 1'b1; n_waddr = cnt + SW'(1); n_wdata = len_p + SW'(1);
        l_re = 1'b1; l_raddr = q;
      end
      sae_pkg::OP_LINK_NQ: begin
        l_we = 1'b1; l_waddr = nq; l_wdata = rd_link;
      end
      sae_pkg::OP_LINK_Q: begin
        l_we = 1'b1; l_waddr = q; l_wdata = nq;
      end
      sae_pkg::OP_COPY_RD: begin
        t_re = 1'b1; t_raddr = q_addr;
      end
      sae_pkg::OP_COPY_WR: begin
        t_we = 1'b1; t_waddr = nq_addr; t_wdata = rd_trans;
      end
      sae_pkg::OP_WALK2_SET: begin
        t_we = 1'b1; t_wdata = nq;
      end
      sae_pkg::OP_LINK_NP_NQ: begin
        l_we = 1'b1; l_wdata = nq;
      end
      default: begin
      end
    endcase
  end

  // memory access, registered reads
  always_ff @(posedge clk) begin
    if (t_we) trans_mem[t_waddr] <= t_wdata;
    if (t_re) rd_trans <= trans_mem[t_raddr];
    if (l_we) link_mem[l_waddr] <= l_wdata;
    if (l_re) rd_link <= link_mem[l_raddr];
    if (n_we) len_mem[n_waddr] <= n_wdata;
    if (n_re) rd_len <= len_mem[n_raddr];
  end

  // walk registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= SW'(1);
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      // post a result, or drop the held one once taken
      if (op == sae_pkg::OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (op)
        sae_pkg::OP_CLEAR: clr <= clr + AW'(1);
        sae_pkg::OP_START: begin
          sym   <= symbol;
          p     <= last_state;
          guard <= '0;
        end
        sae_pkg::OP_REJECT: begin
          np       <= '0;
          full_hit <= st.full;
        end
        sae_pkg::OP_ALLOC_NP: begin
          np       <= cnt + SW'(1);
          cnt      <= cnt + SW'(1);
          full_hit <= 1'b0;
        end
        sae_pkg::OP_WALK_RD: e_addr <= edge_addr;
        sae_pkg::OP_WALK1_SET, sae_pkg::OP_WALK2_SET: begin
          p     <= rd_link;
          guard <= guard + (SW+1)'(1);
        end
        sae_pkg::OP_TAKE_Q:  q     <= rd_trans;
        sae_pkg::OP_READ_LQ: len_p <= rd_len;
        sae_pkg::OP_ALLOC_NQ: begin
          nq    <= cnt + SW'(1);
          cnt   <= cnt + SW'(1);
          guard <= '0;
        end
        sae_pkg::OP_LINK_Q:  idx <= '0;
        sae_pkg::OP_COPY_WR: idx <= idx + OW'(1);
        sae_pkg::OP_RESULT: begin
          new_state  <= np;
          table_full <= full_hit;
        end
        default: begin
        end
      endcase
    end
  end

  // state counter advances by exactly one per allocation
  a_alloc: assert property (@(posedge clk) disable iff (rst)
    (op == sae_pkg::OP_ALLOC_NP || op == sae_pkg::OP_ALLOC_NQ)
      |=> (cnt == $past(cnt) + SW'(1)))
    else $error("state counter did not advance");

  // a full result never carries a state number
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (new_state == '0))
    else $error("full result with nonzero state");

  // a posted result shows up at the output
  a_post: assert property (@(posedge clk) disable iff (rst)
    (op == sae_pkg::OP_RESULT) |=> out_valid)
    else $error("result not posted");

endmodule

// ===== hw/rtl/suffix_automaton_extend_top.sv =====
// ----------------------------------------------------------------------------
// suffix_automaton_extend_top
// Flow: a rejected item goes straight to its result; else the first walk
//   follows suffix links until it reaches the root or meets an edge, and on
//   a clone each row entry is read, then written, through the transition
//   memory before the second walk redirects edges to the clone.
// Throughput: one item at a time; the next is taken the cycle after the result.
// Reset: synchronous; then a clear sweep of all MAX_STATES*ALPHABET_SIZE entries
//   (106496 at defaults) zeroes all stores before the first item is taken.
// ----------------------------------------------------------------------------
module suffix_automaton_extend_top #(
  parameter int MAX_STATES    = 4096,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sae_pkg::SYM_W-1:0]     symbol,
  input  logic [$clog2(MAX_STATES)-1:0] last_state,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [$clog2(MAX_STATES)-1:0] new_state,
  output logic                          table_full
);

  sae_pkg::sae_op_t     op;
  sae_pkg::sae_status_t st;

  // sequencer
  sae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  // stores and walk registers
  sae_dp #(
    .MAX_STATES    (MAX_STATES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .symbol     (symbol),
    .last_state (last_state),
    .out_stall  (out_stall),
    .st         (st),
    .out_valid  (out_valid),
    .new_state  (new_state),
    .table_full (table_full)
  );

endmodule
